>>> sv/hex_char_digit_shifter_assert.svh
// assertion macros for the hex character digit shifter
// needs clk and rst_n in the scope where a macro is used
`ifndef HEX_CHAR_DIGIT_SHIFTER_ASSERT_SVH
`define HEX_CHAR_DIGIT_SHIFTER_ASSERT_SVH

// condition holds in the same cycle
`define HCDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcds check failed");

// condition holds in the next cycle
`define HCDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcds check failed");

`endif

>>> sv/hcds_pkg.sv
// shared types and constants of the hex character digit shifter
// no dependencies
package hcds_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    typedef enum logic [1:0] {
        CMD_DIGIT,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] value;
    } cmd_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return 8'h30 + {4'd0, d};
        end
        return 8'h57 + {4'd0, d};
    endfunction

endpackage

>>> sv/hex_char_digit_shifter.sv
// Hex character digit shifter: each received hex digit character is shifted into a
// register of NUM_DIGITS digits ('<' and '>' pick insert-left or insert-right), and the
// register is then sent back as lower-case hex followed by CR and LF, LF marked last.
// Any other character raises bad_char and gives one status item with tx_valid low.
// A digit item occupies the output for NUM_DIGITS+2 characters (6 at the default), sent
// one character per cycle by the output serializer while out_stall is low; direction
// and unrecognized characters give one status item. Input is taken every cycle while
// the two-entry command queue between the classifier and the serializer has room.
// depends on hcds_pkg, hcds_front, hcds_back and hex_char_digit_shifter_assert.svh
`include "hex_char_digit_shifter_assert.svh"

module hex_char_digit_shifter
    import hcds_pkg::*;
#(
    parameter int NUM_DIGITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] tx_char,
    output logic       tx_valid,
    output logic       last,
    output logic       bad_char,
    output logic       insert_left,
    output logic       out_valid,
    input  logic       out_stall
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    hcds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    hcds_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_char     (tx_char),
        .tx_valid    (tx_valid),
        .last        (last),
        .bad_char    (bad_char),
        .insert_left (insert_left)
    );

    `HCDS_ASSERT_SAME(a_status_single, out_valid && !tx_valid, last)
    `HCDS_ASSERT_SAME(a_digit_no_error, out_valid && tx_valid, !bad_char)
    `HCDS_ASSERT_SAME(a_pop_has_item, q_pop, q_valid)
    `HCDS_ASSERT_SAME(a_end_is_lf, out_valid && tx_valid && last, tx_char == CH_LF)
    `HCDS_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && tx_valid && !last, out_valid && tx_valid)

endmodule

>>> sv/hcds_front.sv
// front end: classifies received characters and queues them as commands
// depends on hcds_pkg
module hcds_front
    import hcds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       q_valid,
    output cmd_t       q_cmd,
    input  logic       q_pop
);

    cmd_t       cmd;
    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    // character classification
    always_comb
    begin
        cmd.kind  = CMD_BAD;
        cmd.value = 4'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            cmd.kind  = CMD_DIGIT;
            cmd.value = char_in[3:0];
        end
        else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                 (char_in >= 8'h61 && char_in <= 8'h66))
        begin
            cmd.kind  = CMD_DIGIT;
            cmd.value = char_in[3:0] + 4'd9;
        end
        else if (char_in == CH_LT)
        begin
            cmd.kind = CMD_LEFT;
        end
        else if (char_in == CH_GT)
        begin
            cmd.kind = CMD_RIGHT;
        end
    end

    assign in_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

>>> sv/hcds_back.sv
// back end: executes queued commands, holds the digit register and status,
// and serializes the transmit characters; depends on hcds_pkg
module hcds_back
    import hcds_pkg::*;
#(
    parameter int NUM_DIGITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_char,
    output logic       tx_valid,
    output logic       last,
    output logic       bad_char,
    output logic       insert_left
);

    localparam int IW = $clog2(NUM_DIGITS + 2);
    localparam int DW = $clog2(NUM_DIGITS);

    logic [3:0]    store_reg  [NUM_DIGITS];
    logic [3:0]    store_next [NUM_DIGITS];
    logic [3:0]    shifted    [NUM_DIGITS];
    logic          dir_reg;
    logic          dir_next;
    logic          err_reg;
    logic          err_next;
    logic          busy_reg;
    logic          busy_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    char_reg;
    logic [7:0]    char_next;
    logic          txv_reg;
    logic          txv_next;
    logic          last_reg;
    logic          last_next;
    logic          load;

    // digit register after shifting in the queued digit
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (dir_reg)
            begin
                shifted[i] = (i == NUM_DIGITS - 1) ? q_cmd.value : store_reg[(i + 1) % NUM_DIGITS];
            end
            else
            begin
                shifted[i] = (i == 0) ? q_cmd.value : store_reg[(i + NUM_DIGITS - 1) % NUM_DIGITS];
            end
        end
    end

    assign load  = !out_valid_reg || !out_stall;
    assign q_pop = load && !busy_reg && q_valid;

    always_comb
    begin
        store_next     = store_reg;
        dir_next       = dir_reg;
        err_next       = err_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        txv_next       = txv_reg;
        last_next      = last_reg;
        if (load)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                txv_next       = 1'b1;
                last_next      = 1'b0;
                idx_next       = idx_reg + IW'(1);
                if (idx_reg < IW'(NUM_DIGITS))
                begin
                    char_next = hex_ascii(store_reg[idx_reg[DW-1:0]]);
                end
                else if (idx_reg == IW'(NUM_DIGITS))
                begin
                    char_next = CH_CR;
                end
                else
                begin
                    char_next = CH_LF;
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else if (q_valid)
            begin
                out_valid_next = 1'b1;
                char_next      = 8'd0;
                txv_next       = 1'b0;
                last_next      = 1'b1;
                case (q_cmd.kind)
                    CMD_DIGIT:
                    begin
                        store_next = shifted;
                        err_next   = 1'b0;
                        char_next  = hex_ascii(shifted[0]);
                        txv_next   = 1'b1;
                        last_next  = 1'b0;
                        busy_next  = 1'b1;
                        idx_next   = IW'(1);
                    end
                    CMD_LEFT:
                    begin
                        dir_next = 1'b1;
                        err_next = 1'b0;
                    end
                    CMD_RIGHT:
                    begin
                        dir_next = 1'b0;
                        err_next = 1'b0;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                store_reg[i] <= 4'd0;
            end
            dir_reg       <= 1'b0;
            err_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            dir_reg       <= dir_next;
            err_reg       <= err_next;
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        txv_reg  <= txv_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign tx_char     = char_reg;
    assign tx_valid    = txv_reg;
    assign last        = last_reg;
    assign bad_char    = err_reg;
    assign insert_left = dir_reg;

endmodule
